// File: rtl/sms_pkg.sv
// Shared types and constants for the spectral magnitude similarity block.
// No dependencies.
package sms_pkg;

    localparam int MAG_W      = 32;    // magnitude width, unsigned Q16.16
    localparam int WIN_W      = 31;    // match window register width
    localparam int SQ_W       = 64;    // width of re^2 + im^2
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int DIV_W      = 64;    // shared divider width
    localparam int WSUM_W     = 64;
    localparam int MSUM_W     = 48;
    localparam int SCORE_W    = 17;
    localparam int FRAC_W     = 16;    // fraction bits of the Q1.16 score
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [WIN_W-1:0] WIN_DEFAULT = WIN_W'(655);

    // register index of match_window
    localparam logic REG_MATCH_WINDOW = 1'b0;

    // start control of an iterative unit; done and busy come back in unit_sts_t
    typedef struct packed {
        logic start;
    } unit_ctl_t;

    typedef struct packed {
        logic done;
        logic busy;
    } unit_sts_t;

endpackage

// File: rtl/sms_regs.sv
// APB configuration register: match_window.
// Depends on sms_pkg.
module sms_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sms_pkg::PADDR_W-1:0]  paddr,
    input  logic [sms_pkg::PDATA_W-1:0]  pwdata,
    output logic [sms_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output logic [sms_pkg::WIN_W-1:0]    win_eff
);

    logic [sms_pkg::WIN_W-1:0] win_reg;
    logic                      reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[sms_pkg::PADDR_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= sms_pkg::WIN_DEFAULT;
        end
        else if (psel && penable && pwrite && (reg_idx == sms_pkg::REG_MATCH_WINDOW))
        begin
            win_reg <= pwdata[sms_pkg::WIN_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == sms_pkg::REG_MATCH_WINDOW)
        begin
            prdata = sms_pkg::PDATA_W'(win_reg);
        end
    end

    // zero window stands for 0.01
    assign win_eff = (win_reg == '0) ? sms_pkg::WIN_DEFAULT : win_reg;

endmodule

// File: rtl/sms_sqrt.sv
// Iterative floor square root, two radicand bits per cycle.
// Depends on sms_pkg.
module sms_sqrt #(
    parameter int W = sms_pkg::SQ_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sms_pkg::unit_ctl_t   ctl,
    input  logic [W-1:0]         value,
    output sms_pkg::unit_sts_t   sts,
    output logic [W/2-1:0]       root
);

    localparam int STEPS = W / 2;
    localparam int CW    = $clog2(STEPS);

    logic [W-1:0]  v_reg, res_reg, bit_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [W-1:0]  trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            v_reg   <= value;
            res_reg <= '0;
            bit_reg <= W'(1) << (W - 2);
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign sts.done = done_reg;
    assign sts.busy = busy_reg;
    assign root     = res_reg[W/2-1:0];

endmodule

// File: rtl/sms_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on sms_pkg.
module sms_div #(
    parameter int W = sms_pkg::DIV_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sms_pkg::unit_ctl_t   ctl,
    input  logic [W-1:0]         dividend,
    input  logic [W-1:0]         divisor,
    output sms_pkg::unit_sts_t   sts,
    output logic [W-1:0]         quotient
);

    localparam int CW = $clog2(W);

    logic [W:0]    rem_reg;
    logic [W-1:0]  quo_reg, dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [W:0]    trial;

    assign trial = {rem_reg[W-1:0], quo_reg[W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_reg <= trial - {1'b0, dvs_reg};
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    assign sts.done = done_reg;
    assign sts.busy = busy_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/spectral_magnitude_similarity.sv
// Spectral magnitude similarity scorer: top level with sequencer and shared multiplier.
// Depends on sms_pkg, sms_regs, sms_sqrt, sms_div.
// A bin reaches the sums after its two square roots and the bin divide; on a last bin
// the score is then offered after the score divide (skipped for an empty frame) and S_OUT.
// A new request is taken only in S_IDLE, once the previous one is through; after a last
// bin S_OUT also waits for the output register to be free.
// Reset (rst_n, async, active low): sums cleared, window back to 655, no result pending.
module spectral_magnitude_similarity (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [31:0]                  test_real,
    input  logic signed [31:0]                  test_imag,
    input  logic signed [31:0]                  ref_real,
    input  logic signed [31:0]                  ref_imag,
    input  logic                                last_bin,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sms_pkg::SCORE_W-1:0]         score,
    output logic                                empty_frame,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sms_pkg::PADDR_W-1:0]         paddr,
    input  logic [sms_pkg::PDATA_W-1:0]         pwdata,
    output logic [sms_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);

    localparam int MW = sms_pkg::MAG_W;

    // Sequencer: squares and root of test bin, then of reference bin, window product,
    // bin divide, accumulate; on a last bin score divide if msum != 0, output.
    typedef enum logic [3:0] {
        S_IDLE, S_SQ_T, S_RT_T, S_SQ_R, S_RT_R, S_WMUL, S_DIV_T, S_ACC, S_DIV_S, S_OUT
    } state_t;

    state_t                          state_reg;
    logic                            step_reg;
    logic                            last_reg;
    logic [MW-1:0]                   ta_reg, tb_reg, ra_reg, rb_reg;
    logic [sms_pkg::SQ_W-1:0]        acc_reg;
    logic [MW-1:0]                   mt_reg, mr_reg;
    logic [sms_pkg::DIV_W-1:0]       div_a_reg, div_b_reg;
    logic [MW-1:0]                   term_reg;
    logic [sms_pkg::WSUM_W-1:0]      wsum_reg;
    logic [sms_pkg::MSUM_W-1:0]      msum_reg;
    logic [sms_pkg::SCORE_W-1:0]     res_score_reg, score_reg;
    logic                            res_empty_reg, empty_reg;
    logic                            out_valid_reg;
    logic                            sqrt_go_reg, div_go_reg;

    logic [sms_pkg::WIN_W-1:0]       win_eff;
    sms_pkg::unit_ctl_t              sqrt_ctl, div_ctl;
    sms_pkg::unit_sts_t              sqrt_sts, div_sts;
    logic [MW-1:0]                   sqrt_root;
    logic [sms_pkg::DIV_W-1:0]       div_quo;

    // shared 32x32 multiplier
    logic [MW-1:0]                   mul_a, mul_b;
    logic [2*MW-1:0]                 mul_p;

    logic [MW-1:0]                   diff;
    logic [MW:0]                     dsum;
    logic [sms_pkg::WSUM_W:0]        wsum_add;
    logic [sms_pkg::MSUM_W:0]        msum_add;
    logic [sms_pkg::WSUM_W-1:0]      wsum_new;
    logic [sms_pkg::MSUM_W-1:0]      msum_new;
    logic [sms_pkg::MSUM_W-1:0]      w_clamp;

    function automatic logic [MW-1:0] abs32(input logic [MW-1:0] v);
        abs32 = v[MW-1] ? (~v + MW'(1)) : v;
    endfunction

    sms_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .win_eff (win_eff)
    );

    assign sqrt_ctl.start = sqrt_go_reg;
    assign div_ctl.start  = div_go_reg;

    sms_sqrt #(.W(sms_pkg::SQ_W)) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (sqrt_ctl),
        .value (acc_reg),
        .sts   (sqrt_sts),
        .root  (sqrt_root)
    );

    sms_div #(.W(sms_pkg::DIV_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_a_reg),
        .divisor  (div_b_reg),
        .sts      (div_sts),
        .quotient (div_quo)
    );

    always_comb
    begin
        unique case (state_reg)
            S_SQ_T:
            begin
                mul_a = step_reg ? tb_reg : ta_reg;
                mul_b = mul_a;
            end
            S_SQ_R:
            begin
                mul_a = step_reg ? rb_reg : ra_reg;
                mul_b = mul_a;
            end
            S_WMUL:
            begin
                mul_a = MW'(win_eff);
                mul_b = mr_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign diff = (mt_reg > mr_reg) ? (mt_reg - mr_reg) : (mr_reg - mt_reg);
    assign dsum = {1'b0, diff} + (MW + 1)'(win_eff);

    // saturating frame sums
    assign wsum_add = {1'b0, wsum_reg} + (sms_pkg::WSUM_W + 1)'(term_reg);
    assign msum_add = {1'b0, msum_reg} + (sms_pkg::MSUM_W + 1)'(mr_reg);
    assign wsum_new = wsum_add[sms_pkg::WSUM_W] ? '1 : wsum_add[sms_pkg::WSUM_W-1:0];
    assign msum_new = msum_add[sms_pkg::MSUM_W] ? '1 : msum_add[sms_pkg::MSUM_W-1:0];
    assign w_clamp  = (wsum_new > sms_pkg::WSUM_W'(msum_new)) ? msum_new
                                                              : wsum_new[sms_pkg::MSUM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= 1'b0;
            wsum_reg      <= '0;
            msum_reg      <= '0;
            out_valid_reg <= 1'b0;
            sqrt_go_reg   <= 1'b0;
            div_go_reg    <= 1'b0;
        end
        else
        begin
            // one-cycle start pulses for the shared units
            sqrt_go_reg <= ((state_reg == S_SQ_T) || (state_reg == S_SQ_R)) && step_reg;
            div_go_reg  <= (state_reg == S_WMUL) ||
                           ((state_reg == S_ACC) && last_reg && (msum_new != '0));
            // result register: loaded from S_OUT when free, dropped on handshake
            out_valid_reg <= ((state_reg == S_OUT) && (!out_valid_reg || out_ready)) ||
                             (out_valid_reg && !out_ready);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        step_reg  <= 1'b0;
                        state_reg <= S_SQ_T;
                    end
                end
                S_SQ_T:
                begin
                    step_reg <= ~step_reg;
                    if (step_reg)
                    begin
                        state_reg <= S_RT_T;
                    end
                end
                S_RT_T:
                begin
                    if (sqrt_sts.done)
                    begin
                        step_reg  <= 1'b0;
                        state_reg <= S_SQ_R;
                    end
                end
                S_SQ_R:
                begin
                    step_reg <= ~step_reg;
                    if (step_reg)
                    begin
                        state_reg <= S_RT_R;
                    end
                end
                S_RT_R:
                begin
                    if (sqrt_sts.done)
                    begin
                        state_reg <= S_WMUL;
                    end
                end
                S_WMUL:
                begin
                    state_reg <= S_DIV_T;
                end
                S_DIV_T:
                begin
                    if (div_sts.done)
                    begin
                        state_reg <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    if (last_reg)
                    begin
                        wsum_reg <= '0;
                        msum_reg <= '0;
                        if (msum_new == '0)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_DIV_S;
                        end
                    end
                    else
                    begin
                        wsum_reg  <= wsum_new;
                        msum_reg  <= msum_new;
                        state_reg <= S_IDLE;
                    end
                end
                S_DIV_S:
                begin
                    if (div_sts.done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                ta_reg   <= abs32(test_real);
                tb_reg   <= abs32(test_imag);
                ra_reg   <= abs32(ref_real);
                rb_reg   <= abs32(ref_imag);
                last_reg <= last_bin;
                acc_reg  <= '0;
            end
            S_SQ_T, S_SQ_R:
            begin
                acc_reg <= acc_reg + mul_p;
            end
            S_RT_T:
            begin
                if (sqrt_sts.done)
                begin
                    mt_reg  <= sqrt_root;
                    acc_reg <= '0;
                end
            end
            S_RT_R:
            begin
                if (sqrt_sts.done)
                begin
                    mr_reg <= sqrt_root;
                end
            end
            S_WMUL:
            begin
                div_a_reg <= mul_p;
                div_b_reg <= sms_pkg::DIV_W'(dsum);
            end
            S_DIV_T:
            begin
                if (div_sts.done)
                begin
                    term_reg <= div_quo[MW-1:0];
                end
            end
            S_ACC:
            begin
                div_a_reg     <= {w_clamp, {sms_pkg::FRAC_W{1'b0}}};
                div_b_reg     <= sms_pkg::DIV_W'(msum_new);
                res_score_reg <= '0;
                res_empty_reg <= 1'b1;
            end
            S_DIV_S:
            begin
                if (div_sts.done)
                begin
                    res_score_reg <= div_quo[sms_pkg::SCORE_W-1:0];
                    res_empty_reg <= 1'b0;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    score_reg <= res_score_reg;
                    empty_reg <= res_empty_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign score       = score_reg;
    assign empty_frame = empty_reg;

endmodule

// File: rtl/sms_checker.sv
// Port-level assertions for the similarity scorer, bound to the top level.
// Depends on sms_pkg and spectral_magnitude_similarity.
module sms_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [sms_pkg::SCORE_W-1:0]   score,
    input logic                          empty_frame
);

    localparam logic [sms_pkg::SCORE_W-1:0] SCORE_ONE =
        sms_pkg::SCORE_W'(1) << sms_pkg::FRAC_W;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(score) && $stable(empty_frame))
        else $error("result dropped or changed while stalled");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_frame |-> score == '0)
        else $error("empty frame with non-zero score");

    a_score_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> score <= SCORE_ONE)
        else $error("score above one");

    a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while previous one in progress");

endmodule

bind spectral_magnitude_similarity sms_checker u_sms_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .score       (score),
    .empty_frame (empty_frame)
);
